[hw/rtl/ir_pulse_modulator_device_defines.svh]
// Assertion helpers shared by the RTL files.
`ifndef IR_PULSE_MODULATOR_DEVICE_DEFINES_SVH
`define IR_PULSE_MODULATOR_DEVICE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define IRPM_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IRPM_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/irpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package irpm_pkg;

  // Width of the cycle time counter, which tick items advance.
  localparam int TIME_W = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TXPL_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RXPL_ADDR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_ADDR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_BIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_VEC   = 3'd5;

  // Item kinds.
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_TICK  = 3'd2;
  localparam logic [2:0] KIND_PIN   = 3'd3;
  localparam logic [2:0] KIND_ACK   = 3'd4;

  // Control register bits.
  localparam int CTRL_TX_EN = 0;
  localparam int CTRL_RX_EN = 1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;
    logic [15:0] pin_port_address;
    logic [2:0]  pin_bit;
    logic        pin_level;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        tx_out_level;
    logic        tx_pin_owned;
    logic        event_accepted;
    logic        irq_pending;
    logic [7:0]  irq_vector;
    logic [15:0] pulse_count;
  } rsp_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic tick_step;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic tick_done;
  } dp_sts_t;

endpackage
`default_nettype wire

[hw/rtl/irpm_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface irpm_req_if;
  import irpm_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[hw/rtl/irpm_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface irpm_rsp_if;
  import irpm_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[hw/rtl/irpm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_modulator_device_defines.svh"
module irpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output irpm_pkg::dp_cmd_t      cmd,
  input  wire irpm_pkg::dp_sts_t sts
);
  import irpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_TICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Sequencing: accept, execute, step the modulator, hand off the result
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.is_tick ? S_TICK : S_DONE;
      end
      S_TICK: begin
        if (sts.tick_done) begin
          state_next = S_DONE;
        end else begin
          cmd.tick_step = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output slot: filled on load, emptied by a transfer
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) rsp_valid_next = 1'b0;
    if (cmd.load_out) rsp_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `IRPM_ASSERT(a_accept_to_exec, clk, rst, (req_valid && req_ready) |=> (state == S_EXEC), "accepted item not executed next")
  `IRPM_ASSERT(a_load_into_free_slot, clk, rst, cmd.load_out |-> slot_free, "result loaded over a waiting result")
  `IRPM_ASSERT(a_step_only_in_tick, clk, rst, cmd.tick_step |-> (state == S_TICK && !sts.tick_done), "modulator stepped outside a tick")

endmodule
`default_nettype wire

[hw/rtl/irpm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_modulator_device_defines.svh"
module irpm_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [irpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [irpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire irpm_pkg::req_item_t                 req_item,
  input  wire irpm_pkg::dp_cmd_t                   cmd,
  output irpm_pkg::dp_sts_t                        sts,
  output irpm_pkg::rsp_item_t                      rsp_item
);
  import irpm_pkg::*;

  // Configuration registers
  logic [15:0] ctrl_addr;
  logic [15:0] txpl_addr;
  logic [15:0] rxpl_addr;
  logic [15:0] pin_addr;
  logic [2:0]  pin_bit_sel;
  logic [7:0]  irq_vec;

  // Block state
  logic [7:0]        control;
  logic [7:0]        tx_period;
  logic [7:0]        rx_threshold;
  logic [7:0]        mod_counter;
  logic              mod_level;
  logic [TIME_W-1:0] cycle_time;
  logic [TIME_W-1:0] last_pulse_time;
  logic              rx_busy;
  logic [15:0]       pulse_counter;

  // Per-item working registers
  req_item_t item;
  logic [7:0] tick_rem;
  logic [7:0] rd_data;
  logic       accepted;
  logic [7:0] vec_out;

  // Decode of the held item
  logic              hit_ctrl;
  logic              hit_txpl;
  logic              hit_rxpl;
  logic              was_tx;
  logic              was_rx;
  logic              now_tx;
  logic              now_rx;
  logic              pin_match;
  logic              irq_grant;
  logic [TIME_W-1:0] elapsed;
  logic [7:0]        thr;
  logic              pulse_long;
  logic [7:0]        read_mux;

  assign hit_ctrl  = (item.bus_address == ctrl_addr);
  assign hit_txpl  = (item.bus_address == txpl_addr);
  assign hit_rxpl  = (item.bus_address == rxpl_addr);
  assign was_tx    = control[CTRL_TX_EN];
  assign was_rx    = control[CTRL_RX_EN];
  assign now_tx    = item.write_data[CTRL_TX_EN];
  assign now_rx    = item.write_data[CTRL_RX_EN];
  assign pin_match = control[CTRL_RX_EN] && (item.pin_port_address == pin_addr) &&
                     (item.pin_bit == pin_bit_sel);
  assign irq_grant = (irq_vec != 8'd0) && rx_busy;
  assign elapsed   = cycle_time - last_pulse_time;
  assign thr       = (rx_threshold == 8'd0) ? 8'd1 : rx_threshold;
  // elapsed >= thr without a full-width compare against a zero-extended byte
  assign pulse_long = (elapsed[TIME_W-1:8] != '0) || (elapsed[7:0] >= thr);

  always_comb begin
    if (hit_ctrl)      read_mux = control;
    else if (hit_txpl) read_mux = tx_period;
    else if (hit_rxpl) read_mux = rx_threshold;
    else               read_mux = 8'd0;
  end

  // Modulator step: jump straight to the next toggle, or absorb the rest
  logic [7:0] period;
  logic [7:0] step_len;
  logic       step_toggle;

  assign period      = (tx_period == 8'd0) ? 8'd1 : tx_period;
  assign step_len    = ({1'b0, mod_counter} + 9'd1 >= {1'b0, period}) ? 8'd1
                       : (period - mod_counter);
  assign step_toggle = (tick_rem >= step_len);

  assign sts.is_tick   = (item.kind == KIND_TICK);
  assign sts.tick_done = (tick_rem == 8'd0) || !control[CTRL_TX_EN];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_addr   <= '0;
      txpl_addr   <= '0;
      rxpl_addr   <= '0;
      pin_addr    <= '0;
      pin_bit_sel <= '0;
      irq_vec     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CTRL_ADDR: ctrl_addr   <= cfg_data;
        CFG_TXPL_ADDR: txpl_addr   <= cfg_data;
        CFG_RXPL_ADDR: rxpl_addr   <= cfg_data;
        CFG_PIN_ADDR:  pin_addr    <= cfg_data;
        CFG_PIN_BIT:   pin_bit_sel <= cfg_data[2:0];
        CFG_IRQ_VEC:   irq_vec     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Item capture and per-item results
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= req_item;
    if (cmd.exec) begin
      rd_data  <= (item.kind == KIND_READ) ? read_mux : 8'd0;
      accepted <= ((item.kind == KIND_PIN) && pin_match) ||
                  ((item.kind == KIND_ACK) && irq_grant);
      vec_out  <= ((item.kind == KIND_ACK) && irq_grant) ? irq_vec : 8'd0;
    end
    if (cmd.load_out) begin
      rsp_item.read_data      <= rd_data;
      rsp_item.tx_out_level   <= mod_level;
      rsp_item.tx_pin_owned   <= control[CTRL_TX_EN];
      rsp_item.event_accepted <= accepted;
      rsp_item.irq_pending    <= irq_grant;
      rsp_item.irq_vector     <= vec_out;
      rsp_item.pulse_count    <= pulse_counter;
    end
  end

  // Peripheral state
  always_ff @(posedge clk) begin
    if (rst) begin
      control         <= '0;
      tx_period       <= '0;
      rx_threshold    <= '0;
      mod_counter     <= '0;
      mod_level       <= 1'b0;
      cycle_time      <= '0;
      last_pulse_time <= '0;
      rx_busy         <= 1'b0;
      pulse_counter   <= '0;
      tick_rem        <= '0;
    end else if (cmd.exec) begin
      case (item.kind)
        KIND_WRITE: begin
          if (hit_ctrl) begin
            control <= item.write_data;
            if (!now_tx || !was_tx) begin
              mod_level   <= 1'b0;
              mod_counter <= '0;
            end
            if (was_rx != now_rx) begin
              rx_busy       <= 1'b0;
              pulse_counter <= '0;
              if (now_rx) last_pulse_time <= cycle_time;
            end
          end else if (hit_txpl) begin
            tx_period <= item.write_data;
          end else if (hit_rxpl) begin
            rx_threshold <= item.write_data;
          end
        end
        KIND_TICK: begin
          cycle_time <= cycle_time + TIME_W'(item.tick_cycles);
          tick_rem   <= item.tick_cycles;
          if (!control[CTRL_TX_EN]) begin
            mod_level   <= 1'b0;
            mod_counter <= '0;
          end
        end
        KIND_PIN: begin
          if (pin_match) begin
            last_pulse_time <= cycle_time;
            if (pulse_long) begin
              pulse_counter <= pulse_counter + 16'd1;
              rx_busy       <= 1'b1;
            end
          end
        end
        KIND_ACK: begin
          if (irq_grant) rx_busy <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.tick_step) begin
      if (step_toggle) begin
        tick_rem    <= tick_rem - step_len;
        mod_counter <= '0;
        mod_level   <= !mod_level;
      end else begin
        mod_counter <= mod_counter + tick_rem;
        tick_rem    <= '0;
      end
    end
  end

  `IRPM_ASSERT(a_step_consumes, clk, rst, (cmd.tick_step && !sts.tick_done) |=> (tick_rem < $past(tick_rem)), "modulator step made no progress")
  `IRPM_ASSERT(a_ack_clears_busy, clk, rst, (cmd.exec && item.kind == KIND_ACK && irq_grant) |=> !rx_busy, "granted acknowledge left busy set")
  `IRPM_ASSERT(a_tx_off_level_low, clk, rst, (cmd.exec && item.kind == KIND_TICK && !control[CTRL_TX_EN]) |=> (!mod_level && mod_counter == 8'd0), "modulator not cleared with transmit off")

endmodule
`default_nettype wire

[hw/rtl/ir_pulse_modulator_device.sv]
`timescale 1ns / 1ps
`default_nettype none
// IR pulse modulator/receiver. Items arrive on req and each produces exactly one
// result on rsp; configuration is to be written through cfg_we/cfg_index/cfg_data
// while idle, which the block itself does not enforce. One item is worked at a time:
// a read, write, pin change, interrupt acknowledge or unused kind is accepted,
// executed and loaded. A tick is accepted and executed, then the modulator step unit
// takes one step per cycle, each jumping to the next toggle point or absorbing the
// cycles left after the last toggle, and the result is loaded; with transmit off no
// steps are taken. A finished result waits in an output register, so the next item
// is accepted while it is still waiting to be taken; a result is loaded only once
// the output register is free.
module ir_pulse_modulator_device (
  input  wire logic                            clk,
  input  wire logic                            rst,
  irpm_req_if.sink                             req,
  irpm_rsp_if.source                           rsp,
  input  wire logic                            cfg_we,
  input  wire logic [irpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [irpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irpm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  irpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Registers, modulator and receiver
  irpm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_item  (req.item),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_item  (rsp.item)
  );

endmodule
`default_nettype wire
